### src/lrast_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared types, widths and constants for the line rasterizer.
// ----------------------------------------------------------------------------
package lrast_pkg;

    localparam int WIDTH       = 512;
    localparam int HEIGHT      = 512;
    localparam int COORD_W     = 9;
    localparam int STEPS_W     = 10;
    localparam int DEC_W       = 12;
    localparam int INDEX_W     = 18;
    localparam int COLOUR_W    = 32;
    localparam int S_DATA_W    = 72;
    localparam int M_DATA_W    = 72;

    typedef enum logic {
        MODE_LINE = 1'b0,
        MODE_TICK = 1'b1
    } mode_t;

    typedef logic [COORD_W-1:0] coord_t;

    // Walker state of one line, loaded by a command and advanced per pixel.
    typedef struct packed {
        coord_t                  cur_x;
        coord_t                  cur_y;
        logic [STEPS_W-1:0]      steps_left;
        logic signed [DEC_W-1:0] decision;
        logic signed [DEC_W-1:0] inc_straight;
        logic signed [DEC_W-1:0] inc_diagonal;
        logic                    x_major;
        logic                    x_negative;
        logic                    y_negative;
    } line_state_t;

endpackage : lrast_pkg
`default_nettype wire

### src/lrast_setup.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_setup
// Derives the initial walker state of a line from its two endpoints:
// octant signs, major axis, step count and midpoint decision terms.
// ----------------------------------------------------------------------------
module lrast_setup
    import lrast_pkg::*;
(
    input  wire coord_t      x_start,
    input  wire coord_t      y_start,
    input  wire coord_t      x_end,
    input  wire coord_t      y_end,
    output line_state_t      init
);

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [COORD_W:0]        adx_w;
    logic [COORD_W:0]        ady_w;
    coord_t                  adx;
    coord_t                  ady;
    logic                    x_major;
    coord_t                  major;
    coord_t                  minor;

    always_comb begin
        dx    = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
        dy    = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
        adx_w = dx[COORD_W] ? (~dx + 1'b1) : dx;
        ady_w = dy[COORD_W] ? (~dy + 1'b1) : dy;
        // A difference of two 9-bit values never exceeds 511 in magnitude.
        adx   = adx_w[COORD_W-1:0];
        ady   = ady_w[COORD_W-1:0];
        x_major = (adx >= ady);
        major = x_major ? adx : ady;
        minor = x_major ? ady : adx;

        init.cur_x        = x_start;
        init.cur_y        = y_start;
        init.steps_left   = {1'b0, major};
        init.inc_straight = $signed({2'b00, minor, 1'b0});
        init.decision     = $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
        init.inc_diagonal = $signed({2'b00, minor, 1'b0}) - $signed({2'b00, major, 1'b0});
        init.x_major      = x_major;
        init.x_negative   = dx[COORD_W];
        init.y_negative   = dy[COORD_W];
    end

endmodule : lrast_setup
`default_nettype wire

### src/line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick transfer's pixel is on m_tdata in the cycle after acceptance, and a line
// of N steps yields N+1 pixels in N+1 ticks. Throughput: one item per cycle
// unless the output stalls. The midpoint update (one add and compare) sets the
// pixel rate. A command transfer gives no result and restarts the walker at once.
// Reset (aresetn low, synchronous) leaves the block idle with no pending result.
// ----------------------------------------------------------------------------
// line_rasterizer
// Bresenham line walker for all octants: a command loads a line, each tick
// emits one pixel write with its frame-buffer index and colour.
// ----------------------------------------------------------------------------
module line_rasterizer
    import lrast_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    // Input: x_start[8:0], y_start[17:9], x_end[26:18], y_end[35:27],
    // red[43:36], green[51:44], blue[59:52], alpha[67:60], zeros above.
    input  wire [S_DATA_W-1:0]   s_tdata,
    input  wire                  s_tuser,   // mode[0]
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // Output: pixel_x[8:0], pixel_y[17:9], pixel_index[35:18], out_red[43:36],
    // out_green[51:44], out_blue[59:52], out_alpha[67:60], zeros above.
    output logic [M_DATA_W-1:0]  m_tdata,
    output logic                 m_tlast,   // last_pixel
    output logic                 m_tvalid,
    input  wire                  m_tready
);

    line_state_t           state_reg, state_next, init;
    logic                  busy_reg, busy_next;
    logic [COLOUR_W-1:0]   colour_reg, colour_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg, m_tlast_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic                  accept;
    logic                  is_line;
    logic                  emit;
    logic                  diag;
    logic                  step_x;
    logic                  step_y;
    logic [INDEX_W-1:0]    index;

    lrast_setup u_setup (
        .x_start (s_tdata[8:0]),
        .y_start (s_tdata[17:9]),
        .x_end   (s_tdata[26:18]),
        .y_end   (s_tdata[35:27]),
        .init    (init)
    );

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_line  = (mode_t'(s_tuser) == MODE_LINE);
    assign emit     = accept && !is_line && busy_reg;

    always_comb begin
        index  = (INDEX_W'(state_reg.cur_y) * INDEX_W'(WIDTH)) + INDEX_W'(state_reg.cur_x);
        diag   = !state_reg.decision[DEC_W-1] && (state_reg.decision != '0);
        step_x = diag || state_reg.x_major;
        step_y = diag || !state_reg.x_major;

        state_next  = state_reg;
        busy_next   = busy_reg;
        colour_next = colour_reg;

        if (accept && is_line) begin
            state_next  = init;
            busy_next   = 1'b1;
            // Stored with red in the top byte, alpha in the bottom byte.
            colour_next = {s_tdata[43:36], s_tdata[51:44], s_tdata[59:52], s_tdata[67:60]};
        end else if (emit) begin
            if (state_reg.steps_left == '0) begin
                busy_next = 1'b0;
            end else begin
                state_next.steps_left = state_reg.steps_left - 1'b1;
                state_next.decision   = state_reg.decision +
                    (diag ? state_reg.inc_diagonal : state_reg.inc_straight);
                if (step_x) begin
                    state_next.cur_x = state_reg.x_negative ? state_reg.cur_x - 1'b1
                                                            : state_reg.cur_x + 1'b1;
                end
                if (step_y) begin
                    state_next.cur_y = state_reg.y_negative ? state_reg.cur_y - 1'b1
                                                            : state_reg.cur_y + 1'b1;
                end
            end
        end
    end

    always_comb begin
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (emit) begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = (state_reg.steps_left == '0);
            m_tdata_next  = {4'b0000, colour_reg[7:0], colour_reg[15:8],
                             colour_reg[23:16], colour_reg[31:24], index,
                             state_reg.cur_y, state_reg.cur_x};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            busy_reg     <= 1'b0;
            colour_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            colour_reg   <= colour_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule : line_rasterizer
`default_nettype wire

### src/lrast_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrast_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lrast_checker
    import lrast_pkg::*;
(
    input wire                 aclk,
    input wire                 aresetn,
    input wire                 s_tuser,
    input wire                 s_tvalid,
    input wire                 s_tready,
    input wire [M_DATA_W-1:0]  m_tdata,
    input wire                 m_tlast,
    input wire                 m_tvalid,
    input wire                 m_tready
);

    // A stalled result must hold until its transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // An empty output register never blocks the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // A command transfer produces no pixel.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == MODE_LINE) && !(m_tvalid && !m_tready)
        |=> !m_tvalid)
        else $error("command produced a pixel");

    // Reset leaves no pending result.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule : lrast_checker

bind line_rasterizer lrast_checker u_lrast_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
`default_nettype wire

### tb/sv/line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_rasterizer_tb
// Self-checking bench for the line walker: drives line commands and ticks
// with random gaps and output stalls, and compares every pixel write against
// a midpoint line predictor kept in a small scoreboard.
// ----------------------------------------------------------------------------
module line_rasterizer_tb;
    import lrast_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 900;
    localparam int MAX_IDLE    = 10;
    localparam int MAX_REPORTS = 10;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;

    // Command payload, lowest field last (x_start sits in the low bits).
    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        coord_t     ye;
        coord_t     xe;
        coord_t     ys;
        coord_t     xs;
    } line_cmd_t;

    // One pixel write as seen on {m_tlast, m_tdata[67:0]}.
    typedef struct packed {
        logic               last;
        logic [7:0]         alpha;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic [INDEX_W-1:0] index;
        coord_t             y;
        coord_t             x;
    } pixel_t;

    class pixel_scoreboard;
        pixel_t             pending[$];
        line_state_t        walk;
        logic               busy;
        logic [COLOUR_W-1:0] colour;
        int                 useful;
        int                 checked;
        int                 ends_seen;
        int                 mismatches;

        function new();
            walk       = '0;
            busy       = 1'b0;
            colour     = '0;
            useful     = 0;
            checked    = 0;
            ends_seen  = 0;
            mismatches = 0;
        endfunction

        // Called for every accepted input transfer; queues the pixel a tick causes, if any.
        function void note_transfer(mode_t mode, line_cmd_t cmd);
            logic signed [COORD_W:0]  dx;
            logic signed [COORD_W:0]  dy;
            logic signed [DEC_W-1:0]  major;
            logic signed [DEC_W-1:0]  minor;
            pixel_t                   px;
            if (mode == MODE_LINE) begin
                dx = $signed({1'b0, cmd.xe}) - $signed({1'b0, cmd.xs});
                dy = $signed({1'b0, cmd.ye}) - $signed({1'b0, cmd.ys});
                walk.x_negative = dx < 0;
                walk.y_negative = dy < 0;
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                walk.x_major = dx >= dy;
                major = walk.x_major ? DEC_W'(dx) : DEC_W'(dy);
                minor = walk.x_major ? DEC_W'(dy) : DEC_W'(dx);
                walk.cur_x        = cmd.xs;
                walk.cur_y        = cmd.ys;
                walk.steps_left   = major[STEPS_W-1:0];
                walk.decision     = DEC_W'(2 * minor - major);
                walk.inc_straight = DEC_W'(2 * minor);
                walk.inc_diagonal = DEC_W'(2 * (minor - major));
                colour = {cmd.red, cmd.green, cmd.blue, cmd.alpha};
                busy   = 1'b1;
                useful++;
                return;
            end
            if (!busy) return;
            useful++;
            px.x     = walk.cur_x;
            px.y     = walk.cur_y;
            px.index = INDEX_W'(walk.cur_y * WIDTH + walk.cur_x);
            px.red   = colour[31:24];
            px.green = colour[23:16];
            px.blue  = colour[15:8];
            px.alpha = colour[7:0];
            px.last  = walk.steps_left == '0;
            pending.push_back(px);
            if (px.last) begin
                busy = 1'b0;
                return;
            end
            // On a tie the minor axis holds still.
            if (walk.decision > 0) begin
                walk.decision = walk.decision + walk.inc_diagonal;
                walk.cur_x = walk.x_negative ? walk.cur_x - 1'b1 : walk.cur_x + 1'b1;
                walk.cur_y = walk.y_negative ? walk.cur_y - 1'b1 : walk.cur_y + 1'b1;
            end else begin
                walk.decision = walk.decision + walk.inc_straight;
                if (walk.x_major)
                    walk.cur_x = walk.x_negative ? walk.cur_x - 1'b1 : walk.cur_x + 1'b1;
                else
                    walk.cur_y = walk.y_negative ? walk.cur_y - 1'b1 : walk.cur_y + 1'b1;
            end
            walk.steps_left = walk.steps_left - 1'b1;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected pixel write: x=%0d y=%0d index=%0d last=%0b",
                             got.x, got.y, got.index, got.last);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.last) ends_seen++;
            if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Pixel %0d expected x=%0d y=%0d index=%0d rgba=%h%h%h%h last=%0b",
                             checked, want.x, want.y, want.index, want.red, want.green,
                             want.blue, want.alpha, want.last);
                    $display("Pixel %0d actual   x=%0d y=%0d index=%0d rgba=%h%h%h%h last=%0b",
                             checked, got.x, got.y, got.index, got.red, got.green,
                             got.blue, got.alpha, got.last);
                end
            end
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                s_tuser = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    pixel_scoreboard board;
    int  cycle_count = 0;
    bit  s_steady = 1'b0;
    bit  m_steady = 1'b0;
    int  lines_drawn = 0;
    int  lines_cut = 0;

    line_rasterizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic line_cmd_t noise();
        logic [95:0] bits;
        bits = {$urandom(), $urandom(), $urandom()};
        return bits[67:0];
    endfunction

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > COORD_MAX) return COORD_MAX;
        return v;
    endfunction

    task automatic send_item(mode_t mode, line_cmd_t cmd);
        int gap;
        if ($urandom_range(0, 39) == 0) s_steady = !s_steady;
        gap = s_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= mode;
        s_tdata  <= {4'b0, cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_transfer(mode, cmd);
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_item(MODE_TICK, noise());
    endtask

    task automatic send_line(int xs, int ys, int xe, int ye, logic [31:0] rgba);
        line_cmd_t cmd;
        cmd.xs = coord_t'(xs);
        cmd.ys = coord_t'(ys);
        cmd.xe = coord_t'(xe);
        cmd.ye = coord_t'(ye);
        {cmd.red, cmd.green, cmd.blue, cmd.alpha} = rgba;
        lines_drawn++;
        send_item(MODE_LINE, cmd);
    endtask

    // Result side: a random stall before each pixel write is taken.
    initial begin : pixel_sink
        int stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0) m_steady = !m_steady;
            stall = m_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_pixel({m_tlast, m_tdata[67:0]});
        end
    end

    initial begin : stimulus
        int xs, ys, xe, ye, span, ticks, pick;
        board = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Tick with nothing loaded, then a single point and a tick after its end.
        send_ticks(1);
        send_line(0, 0, 0, 0, 32'h0000_0000);
        send_ticks(2);
        // Full-diagonal line, cut short by the next command.
        send_line(0, 0, COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
        send_ticks(2);
        // Short lines in four octants, each with a tie on its first step.
        send_line(256, 256, 258, 257, 32'h1234_5678);
        send_ticks(3);
        send_line(256, 256, 255, 258, 32'h8765_4321);
        send_ticks(3);
        send_line(256, 256, 254, 255, 32'h0F0F_F0F0);
        send_ticks(3);
        send_line(256, 256, 257, 254, 32'hF0F0_0F0F);
        send_ticks(3);
        send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 32'hA5C3_5A3C);
        send_ticks(1);

        while (board.useful < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_ticks($urandom_range(1, 3));
            end else begin
                xs = $urandom_range(0, COORD_MAX);
                ys = $urandom_range(0, COORD_MAX);
                if ($urandom_range(0, 9) == 0) xs = $urandom_range(0, 1) ? COORD_MAX : 0;
                if ($urandom_range(0, 9) == 0) ys = $urandom_range(0, 1) ? COORD_MAX : 0;
                if (pick < 18) begin
                    xe = $urandom_range(0, COORD_MAX);
                    ye = $urandom_range(0, COORD_MAX);
                end else begin
                    xe = clamp_coord(xs + $urandom_range(0, 24) - 12);
                    ye = clamp_coord(ys + $urandom_range(0, 24) - 12);
                end
                span = (xe > xs) ? xe - xs : xs - xe;
                if (((ye > ys) ? ye - ys : ys - ye) > span)
                    span = (ye > ys) ? ye - ys : ys - ye;
                ticks = span + 1;
                if ($urandom_range(0, 4) == 0) begin
                    ticks = $urandom_range(0, span);
                    lines_cut++;
                end else if ($urandom_range(0, 3) == 0) begin
                    ticks += $urandom_range(1, 2);
                end
                // Keep the last line from running far past the item budget.
                if (ticks > ITEM_TARGET - board.useful - 1)
                    ticks = ITEM_TARGET - board.useful - 1;
                send_line(xs, ys, xe, ye, $urandom());
                send_ticks(ticks);
            end
        end
        s_tvalid <= 1'b0;

        while (board.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d line commands in all octants, %0d of them cut short by a new one.",
                 lines_drawn, lines_cut);
        $display("Compared %0d pixel writes, %0d of them line ends; %0d mismatches.",
                 board.checked, board.ends_seen, board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### line_rasterizer.f
src/lrast_pkg.sv
src/lrast_setup.sv
src/line_rasterizer.sv
src/lrast_checker.sv
tb/sv/line_rasterizer_tb.sv
